// ===== src/ssq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable sorted priority queue package
// Shared entry type, cell control bundle, command and status codes.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int TIME_W   = 7;
  localparam int INFO_W   = 8;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [TIME_W-1:0] tm;
    logic [INFO_W-1:0] info;
  } entry_t;

  typedef struct packed {
    logic   do_ins;
    logic   do_rem;
    entry_t ent;
  } cell_ctrl_t;

endpackage

// ===== src/ssq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable sorted priority queue cell
// Holds one entry of the sorted chain and shifts with its neighbors.
// ----------------------------------------------------------------------------
module ssq_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  ssq_pkg::cell_ctrl_t         ctrl,
  input  logic [ssq_pkg::CNT_W-1:0]   count,
  input  logic                        left_le,
  input  ssq_pkg::entry_t             left_ent,
  input  ssq_pkg::entry_t             right_ent,
  output logic                        le,
  output ssq_pkg::entry_t             ent
);
  import ssq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;
  logic   occ;

  assign occ = (int'(count) > IDX);
  // An occupied entry with a time not above the new one stays ahead of it.
  assign le  = occ && (ent_r.tm <= ctrl.ent.tm);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.do_ins) begin
      if (le) begin
        ent_nxt = ent_r;
      end else if (left_le) begin
        ent_nxt = ctrl.ent;
      end else begin
        ent_nxt = left_ent;
      end
    end else if (ctrl.do_rem) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.do_ins || ctrl.do_rem) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// ===== src/stable_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable sorted priority queue
// Bounded queue of (time, info) entries held in a sorted chain of cells.
// ----------------------------------------------------------------------------
// Every cell of the chain updates in the same cycle, so the queue accepts one
// insert or remove request per clock while in_ready is high and registers its
// result for the next cycle. in_ready drops only while a result waits to be
// taken; throughput is one request per cycle as long as out_ready stays high.
// Entries with equal times leave in arrival order. The capacity register
// limits the fill level (saturating at DEPTH, at most 31); a zero capacity
// refuses all inserts. Entry storage needs no clearing after reset.
module stable_sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [ssq_pkg::TIME_W-1:0]     in_entry_time,
  input  logic [ssq_pkg::INFO_W-1:0]     in_entry_info,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ssq_pkg::TIME_W-1:0]     out_time,
  output logic [ssq_pkg::INFO_W-1:0]     out_info,
  output logic [ssq_pkg::STATUS_W-1:0]   out_status,
  output logic [ssq_pkg::CNT_W-1:0]      out_count,
  input  logic                           cfg_we,
  input  logic [ssq_pkg::CNT_W-1:0]      cfg_wdata
);
  import ssq_pkg::*;

  localparam int LIMIT_MAX_I = (DEPTH > 31) ? 31 : DEPTH;
  localparam logic [CNT_W-1:0] LIMIT_MAX = LIMIT_MAX_I[CNT_W-1:0];

  logic [CNT_W-1:0]    cap_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [CNT_W-1:0]    limit;
  logic                out_valid_r;
  logic [TIME_W-1:0]   out_time_r;
  logic [INFO_W-1:0]   out_info_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CNT_W-1:0]    out_count_r;

  logic       accept;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;

  entry_t ents [DEPTH];
  logic   les  [DEPTH];

  assign limit    = (cap_r > LIMIT_MAX) ? LIMIT_MAX : cap_r;
  assign full     = (cnt_r >= limit);
  assign empty    = (cnt_r == '0);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign ctrl.do_ins  = accept && (in_cmd == CMD_INSERT) && !full;
  assign ctrl.do_rem  = accept && (in_cmd == CMD_REMOVE) && !empty;
  assign ctrl.ent.tm   = in_entry_time;
  assign ctrl.ent.info = in_entry_info;

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.do_ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctrl.do_rem) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic   l_le;
      entry_t l_ent;
      entry_t r_ent;
      if (g == 0) begin : g_head
        assign l_le  = 1'b1;
        assign l_ent = ctrl.ent;
      end else begin : g_mid
        assign l_le  = les[g-1];
        assign l_ent = ents[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
        assign r_ent = ents[g];
      end else begin : g_body
        assign r_ent = ents[g+1];
      end
      ssq_cell #(.IDX(g)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .count     (cnt_r),
        .left_le   (l_le),
        .left_ent  (l_ent),
        .right_ent (r_ent),
        .le        (les[g]),
        .ent       (ents[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_time_r   <= ctrl.do_rem ? ents[0].tm : '0;
      out_info_r   <= ctrl.do_rem ? ents[0].info : '0;
      out_count_r  <= cnt_nxt;
      if (in_cmd == CMD_INSERT && full) begin
        out_status_r <= ST_FULL;
      end else if (in_cmd == CMD_REMOVE && empty) begin
        out_status_r <= ST_EMPTY;
      end else begin
        out_status_r <= ST_DONE;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_time   = out_time_r;
  assign out_info   = out_info_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

// ===== src/ssq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable sorted priority queue checker
// Port-level checks on results of the queue, bound to the top level.
// ----------------------------------------------------------------------------
module ssq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [ssq_pkg::TIME_W-1:0]     out_time,
  input logic [ssq_pkg::INFO_W-1:0]     out_info,
  input logic [ssq_pkg::STATUS_W-1:0]   out_status,
  input logic [ssq_pkg::CNT_W-1:0]      out_count
);
  import ssq_pkg::*;

  // A refused remove only happens on an empty queue.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_count == '0))
    else $error("empty status with nonzero count");

  // A refused request carries no entry.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_time == '0 && out_info == '0))
    else $error("refused request carries entry data");

  // Status never takes the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_EMPTY ||
                   out_status == ST_FULL))
    else $error("invalid status code");

  // An accepted request shows up the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request gave no result");

  // A stalled result holds its count.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_count)))
    else $error("stalled result changed");

endmodule

bind stable_sorted_priority_queue ssq_checker u_ssq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_time   (out_time),
  .out_info   (out_info),
  .out_status (out_status),
  .out_count  (out_count)
);
